/* hdl/gfe_pkg.sv */
// ----------------------------------------------------------------------------
// gfe_pkg
// Shared types, constants and the sequencer state enum of the elimination unit.
// ----------------------------------------------------------------------------
`default_nettype none
package gfe_pkg;
   localparam int MAX_ROWS = 8;
   localparam int MAX_COLS = 16;
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ADDR_W   = ROW_W + COL_W;
   localparam int DEPTH    = MAX_ROWS * MAX_COLS;

   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_RUN  = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   localparam logic [1:0] CSR_ROWS = 2'd0;
   localparam logic [1:0] CSR_COLS = 2'd1;
   localparam logic [1:0] CSR_EPS  = 2'd2;

   localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] S32_MIN = 32'sh80000000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_COL,
      ST_PIV_WAIT,
      ST_PIV_CHECK,
      ST_COEF_WAIT,
      ST_COEF_DIV,
      ST_ELIM_RD,
      ST_ELIM_MUL,
      ST_ELIM_WR,
      ST_NORM_DIAG,
      ST_NORM_RD,
      ST_NORM_DIV,
      ST_DONE
   } state_type;

   // Clamp a wide signed value to the 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'(S32_MAX)) begin
         r = S32_MAX;
      end else if (v < 66'(S32_MIN)) begin
         r = S32_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction
endpackage
`default_nettype wire

/* hdl/gaussian_forward_elimination_unit.sv */
// ----------------------------------------------------------------------------
// gaussian_forward_elimination_unit
// Q16.16 matrix store with in-place forward elimination and row normalization.
// ----------------------------------------------------------------------------
// A run walks each column's lower rows: per row one pivot read and one
// coefficient divide, then per column in use a read, a registered multiply
// and a write. Normalization does one diagonal read per row, then one divide
// per element on the shared divider. The single-port matrix RAM and the
// serial divider bound the length of a full 8x9 run. Every word yields one
// rsp_strobe pulse that the receiver must take in that cycle.
`default_nettype none
module gaussian_forward_elimination_unit import gfe_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_action,
   input  wire logic [2:0]         req_row_index,
   input  wire logic [3:0]         req_col_index,
   input  wire logic signed [31:0] req_element_value,
   output logic                    rsp_strobe,
   output logic signed [31:0]      rsp_read_value,
   output logic                    rsp_status,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_data
);
   state_type state_ff, state_in;

   logic [3:0]  rows_cfg_ff;
   logic [4:0]  cols_cfg_ff;
   logic [15:0] eps_ff;
   logic [4:0]  rows_use, cols_use;

   logic [ROW_W:0] c_ff, c_in, r_ff, r_in;   // c also runs as column index
   logic [COL_W:0] k_ff, k_in;
   logic signed [31:0] piv_ff, piv_in, coef_ff, coef_in;
   logic signed [31:0] mul_ff;
   logic sing_ff, sing_in;
   logic strobe_ff, strobe_in;
   logic signed [31:0] rval_ff, rval_in;
   logic rd_pend_ff, rd_pend_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [31:0]       ram_wd, ram_rd;
   logic              div_start, div_done;
   logic signed [31:0] div_num, div_den, div_q;
   logic signed [63:0] full_prod;
   logic signed [65:0] diff;

   gfe_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wd), .rd_data_ff(ram_rd)
   );
   gfe_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .done_ff(div_done), .quot_ff(div_q)
   );

   assign rows_use = (rows_cfg_ff > 4'(MAX_ROWS)) ? 5'(MAX_ROWS) : 5'(rows_cfg_ff);
   assign cols_use = (cols_cfg_ff > 5'(MAX_COLS)) ? 5'(MAX_COLS) : cols_cfg_ff;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_read_value = rval_ff;
   assign rsp_status     = sing_ff;

   function automatic logic [ADDR_W-1:0] adr(input logic [ROW_W:0] r,
                                            input logic [COL_W:0] c);
      return {r[ROW_W-1:0], c[COL_W-1:0]};
   endfunction

   // pivot-row element arrives on ram_rd in ST_ELIM_MUL, product lands in mul_ff
   always_comb begin
      full_prod = 64'($signed(ram_rd)) * 64'(coef_ff);
      diff = 66'($signed(ram_rd)) - 66'(mul_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               priority if (req_action == ACT_RUN) state_in = ST_COL;
               else if (req_action == ACT_READ) state_in = ST_READ_WAIT;
               else state_in = ST_DONE;
            end
         end
         ST_READ_WAIT: state_in = ST_DONE;
         ST_COL: begin
            priority if (5'(c_ff) >= cols_use || 5'(c_ff) >= rows_use)
               state_in = ST_NORM_DIAG;
            else if (5'(r_ff) >= rows_use) state_in = ST_COL;
            else state_in = ST_PIV_WAIT;
         end
         ST_PIV_WAIT: state_in = ST_PIV_CHECK;
         ST_PIV_CHECK: begin
            if (((ram_rd[31] ? 33'(-$signed({ram_rd[31], ram_rd})) : 33'(ram_rd)))
                < 33'(eps_ff))
               state_in = ST_DONE;
            else state_in = ST_COEF_WAIT;
         end
         ST_COEF_WAIT: state_in = ST_COEF_DIV;
         ST_COEF_DIV:  if (div_done) state_in = ST_ELIM_RD;
         ST_ELIM_RD: begin
            if (5'(k_ff) >= cols_use) state_in = ST_COL;
            else state_in = ST_ELIM_MUL;
         end
         ST_ELIM_MUL: state_in = ST_ELIM_WR;
         ST_ELIM_WR:  state_in = ST_ELIM_RD;
         ST_NORM_DIAG: begin
            if (5'(r_ff) >= rows_use || 5'(r_ff) >= cols_use) state_in = ST_DONE;
            else state_in = ST_NORM_RD;
         end
         ST_NORM_RD: begin
            if (5'(k_ff) >= cols_use) state_in = ST_NORM_DIAG;
            else state_in = ST_NORM_DIV;
         end
         ST_NORM_DIV: if (div_done) state_in = ST_NORM_RD;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      c_in = c_ff; r_in = r_ff; k_in = k_ff;
      piv_in = piv_ff; coef_in = coef_ff;
      sing_in = sing_ff; strobe_in = 1'b0; rval_in = rval_ff;
      rd_pend_in = rd_pend_ff;
      ram_we = 1'b0; ram_addr = adr(r_ff, k_ff); ram_wd = '0;
      div_start = 1'b0; div_num = '0; div_den = piv_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ram_addr = {req_row_index, req_col_index};
            rval_in  = '0;
            if (start) begin
               priority if (req_action == ACT_LOAD) begin
                  ram_we = 1'b1;
                  ram_wd = req_element_value;
               end else if (req_action == ACT_RUN) begin
                  sing_in = 1'b0;
                  c_in = '0; r_in = (ROW_W+1)'(1);
               end else begin
                  rd_pend_in = (req_action == ACT_READ);
               end
            end
         end
         ST_READ_WAIT: begin
            rval_in = ram_rd;
         end
         ST_COL: begin
            ram_addr = adr(c_ff, (COL_W+1)'(c_ff));
            if (5'(r_ff) >= rows_use) begin
               // advance to next column
               c_in = c_ff + 1'b1;
               r_in = c_ff + 2'd2;
            end
            if (5'(c_ff) >= cols_use || 5'(c_ff) >= rows_use) r_in = '0;
         end
         ST_PIV_WAIT: ram_addr = adr(c_ff, (COL_W+1)'(c_ff));
         ST_PIV_CHECK: begin
            ram_addr = adr(r_ff, (COL_W+1)'(c_ff));
            piv_in = ram_rd;
            if (((ram_rd[31] ? 33'(-$signed({ram_rd[31], ram_rd})) : 33'(ram_rd)))
                < 33'(eps_ff))
               sing_in = 1'b1;
         end
         ST_COEF_WAIT: begin
            div_start = 1'b1; div_num = ram_rd; div_den = piv_ff;
            k_in = '0;
         end
         ST_COEF_DIV: if (div_done) coef_in = div_q;
         ST_ELIM_RD: begin
            ram_addr = adr(c_ff, k_ff);
            if (5'(k_ff) >= cols_use) r_in = r_ff + 1'b1;
         end
         ST_ELIM_MUL: begin
            ram_addr = adr(r_ff, k_ff);
         end
         ST_ELIM_WR: begin
            ram_addr = adr(r_ff, k_ff);
            ram_we = 1'b1;
            ram_wd = sat32(diff);
            k_in = k_ff + 1'b1;
         end
         ST_NORM_DIAG: begin
            ram_addr = adr(r_ff, (COL_W+1)'(r_ff));
            k_in = '0;
         end
         ST_NORM_RD: begin
            // first pass here holds the saved diagonal on ram_rd
            if (k_ff == '0 && !rd_pend_ff) begin
               piv_in = ram_rd;
            end
            ram_addr = adr(r_ff, k_ff);
            if (5'(k_ff) >= cols_use) r_in = r_ff + 1'b1;
            rd_pend_in = 1'b0;
         end
         ST_NORM_DIV: begin
            ram_addr = adr(r_ff, k_ff);
            if (!rd_pend_ff) begin
               div_start = 1'b1; div_num = ram_rd;
               rd_pend_in = 1'b1;
            end
            if (div_done) begin
               ram_we = 1'b1; ram_wd = div_q;
               k_in = k_ff + 1'b1;
            end
         end
         ST_DONE: begin
            strobe_in = 1'b1;
            rd_pend_in = 1'b0;
         end
         default: ;
      endcase
   end

   // product of pivot-row element and coefficient, registered before subtract
   always_ff @(posedge clock) begin
      mul_ff <= sat32(66'(full_prod / 64'sd65536));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rows_cfg_ff <= 4'd8;
         cols_cfg_ff <= 5'd9;
         eps_ff      <= 16'd7;
         sing_ff     <= 1'b0;
         strobe_ff   <= 1'b0;
         rd_pend_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sing_ff    <= sing_in;
         strobe_ff  <= strobe_in;
         rd_pend_ff <= (state_ff == ST_NORM_DIAG) ? 1'b0 : rd_pend_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ROWS: rows_cfg_ff <= csr_data[3:0];
               CSR_COLS: cols_cfg_ff <= csr_data[4:0];
               CSR_EPS:  eps_ff      <= csr_data;
               default: ;
            endcase
         end
      end
      c_ff <= c_in; r_ff <= r_in; k_ff <= k_in;
      piv_ff <= piv_in; coef_ff <= coef_in;
      rval_ff <= rval_in;
   end
endmodule
`default_nettype wire

/* hdl/gfe_ram.sv */
// ----------------------------------------------------------------------------
// gfe_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module gfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end
endmodule
`default_nettype wire

/* hdl/gfe_div.sv */
// ----------------------------------------------------------------------------
// gfe_div
// Restoring divider: sat((a*65536)/b), truncated toward zero, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module gfe_div import gfe_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] num,
   input  wire logic signed [31:0] den,
   output logic                    done_ff,
   output logic signed [31:0]      quot_ff
);
   localparam int QW = 48;
   localparam int CW = $clog2(QW + 1);

   logic [QW-1:0] dvd_ff, dvd_in;
   logic [QW-1:0] q_ff, q_in;
   logic [32:0]   rem_ff, rem_in;
   logic [31:0]   dvs_ff, dvs_in;
   logic          neg_ff, neg_in;
   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_in;
   logic signed [31:0] quot_in;
   logic [32:0]   trial;
   logic [QW-1:0] q_next;
   logic signed [65:0] sq;
   logic [31:0]   anum, aden;

   always_comb begin
      anum    = num[31] ? 32'(-num) : 32'(num);
      aden    = den[31] ? 32'(-den) : 32'(den);
      dvd_in  = dvd_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      quot_in = quot_ff;
      trial   = {rem_ff[31:0], dvd_ff[QW-1]};
      q_next  = {q_ff[QW-2:0], 1'b0};
      sq      = '0;
      if (start) begin
         priority if (den == 32'sd0) begin
            done_in = 1'b1;
            quot_in = (num > 0) ? S32_MAX : ((num < 0) ? S32_MIN : 32'sd0);
         end else begin
            dvd_in  = {anum, 16'd0};
            q_in    = '0;
            rem_in  = '0;
            dvs_in  = aden;
            neg_in  = num[31] ^ den[31];
            busy_in = 1'b1;
            cnt_in  = CW'(QW);
         end
      end else if (busy_ff) begin
         // shift one dividend bit in, subtract where it fits
         dvd_in = {dvd_ff[QW-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            q_next[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         q_in   = q_next;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            sq = neg_ff ? -$signed({18'd0, q_next}) : $signed({18'd0, q_next});
            quot_in = sat32(sq);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff  <= dvd_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
   end
endmodule
`default_nettype wire

/* hdl/gfe_checker.sv */
// ----------------------------------------------------------------------------
// gfe_checker
// Port-level checks of the elimination unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module gfe_checker import gfe_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic [1:0]  req_action,
   input wire logic        rsp_strobe,
   input wire logic [31:0] rsp_read_value,
   input wire logic        rsp_status,
   input wire logic        csr_ready
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accept did not raise busy");
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("strobe held two cycles");
   a_load_zero: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_action == ACT_LOAD |=> ##1 rsp_strobe && rsp_read_value == 32'd0)
      else $error("load word not returned as zero");
   a_load_status: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_action == ACT_LOAD |=> ##1 rsp_status == $past(rsp_status, 2))
      else $error("load changed status");
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !busy) else $error("csr ready while busy");
endmodule

bind gaussian_forward_elimination_unit gfe_checker u_gfe_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_action(req_action), .rsp_strobe(rsp_strobe),
   .rsp_read_value(rsp_read_value), .rsp_status(rsp_status), .csr_ready(csr_ready)
);
`default_nettype wire
